// ===== rtl/source_text_tokenizer_top_macros.svh =====
// Assertion helpers for the tokenizer RTL.
`ifndef SOURCE_TEXT_TOKENIZER_TOP_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define STT_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tokenizer check failed");
// The condition must never be true outside reset.
`define STT_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("tokenizer forbidden condition seen");
`else
`define STT_ASSERT(name, clk, rst_n, prop)
`define STT_NEVER(name, clk, rst_n, cond)
`endif
`endif

// ===== rtl/stt_pkg.sv =====
package stt_pkg;

    // Width of the running byte position; token_start carries its low 16 bits.
    localparam int POS_BITS = 16;
    // Letters a keyword register can hold.
    localparam int KW_LETTERS = 8;
    localparam int WBUF_W = KW_LETTERS * 8;
    localparam int NUM_WORDS = 4;
    localparam int LEN_W = 16;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_PRINT = 2'd0,
        REG_FALSE = 2'd1,
        REG_TRUE  = 2'd2,
        REG_INT   = 2'd3
    } reg_index_t;

    localparam logic [63:0] PRINT_RESET = 64'd500068610672;
    localparam logic [63:0] FALSE_RESET = 64'd435728179558;
    localparam logic [63:0] TRUE_RESET  = 64'd1702195828;
    localparam logic [63:0] INT_RESET   = 64'd7630441;

    typedef logic [NUM_WORDS-1:0][63:0] kw_words_t;

    // Token kinds.
    localparam logic [4:0] K_EOF        = 5'd0;
    localparam logic [4:0] K_NUMBER     = 5'd1;
    localparam logic [4:0] K_IDENT      = 5'd2;
    localparam logic [4:0] K_PRINT      = 5'd3;
    localparam logic [4:0] K_FALSE      = 5'd4;
    localparam logic [4:0] K_TRUE       = 5'd5;
    localparam logic [4:0] K_INT        = 5'd6;
    localparam logic [4:0] K_PLUS       = 5'd7;
    localparam logic [4:0] K_PLUS_PLUS  = 5'd8;
    localparam logic [4:0] K_PLUS_EQ    = 5'd9;
    localparam logic [4:0] K_MINUS      = 5'd10;
    localparam logic [4:0] K_MINUS_MIN  = 5'd11;
    localparam logic [4:0] K_MINUS_EQ   = 5'd12;
    localparam logic [4:0] K_STAR       = 5'd13;
    localparam logic [4:0] K_STAR_EQ    = 5'd14;
    localparam logic [4:0] K_SLASH      = 5'd15;
    localparam logic [4:0] K_SLASH_EQ   = 5'd16;
    localparam logic [4:0] K_ASSIGN     = 5'd17;
    localparam logic [4:0] K_EQ_EQ      = 5'd18;
    localparam logic [4:0] K_NOT_EQ     = 5'd19;
    localparam logic [4:0] K_AND_AND    = 5'd20;
    localparam logic [4:0] K_OR_OR      = 5'd21;
    localparam logic [4:0] K_STRING     = 5'd22;
    localparam logic [4:0] K_SEMI       = 5'd23;
    localparam logic [4:0] K_BAD        = 5'd24;

    // ASCII codes the scanner reacts to.
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_PIPE  = 8'h7C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Scanner modes.
    typedef enum logic [3:0] {
        M_IDLE   = 4'd0,
        M_NUMBER = 4'd1,
        M_WORD   = 4'd2,
        M_PLUS   = 4'd3,
        M_MINUS  = 4'd4,
        M_STAR   = 4'd5,
        M_SLASH  = 4'd6,
        M_EQUAL  = 4'd7,
        M_BANG   = 4'd8,
        M_AMP    = 4'd9,
        M_PIPE   = 4'd10,
        M_QUOTE  = 4'd11,
        M_STRING = 4'd12
    } mode_t;

    // One emitted token.
    typedef struct packed {
        logic [4:0]       kind;
        logic [15:0]      start;
        logic [LEN_W-1:0] length;
        logic             last;
    } result_t;

    // Tokens handed from the scanner to the output buffer in one cycle.
    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage

// ===== rtl/stt_scan.sv =====
module stt_scan (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] text_byte
    input  logic                  s_tlast,   // end_of_text
    input  stt_pkg::kw_words_t    words,
    input  logic [1:0]            space,
    output stt_pkg::push_t        push
);
    import stt_pkg::*;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c inside {[8'd9:8'd13]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'd48:8'd57]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {[8'd65:8'd90]}) || (c inside {[8'd97:8'd122]});
    endfunction

    // Kind of the two-byte operator formed by a pending operator and c, or zero.
    function automatic logic [4:0] pair_kind(input mode_t m, input logic [7:0] c);
        logic [4:0] k;
        k = 5'd0;
        case (m)
            M_PLUS:  k = (c == CH_PLUS) ? K_PLUS_PLUS : ((c == CH_EQUAL) ? K_PLUS_EQ : 5'd0);
            M_MINUS: k = (c == CH_MINUS) ? K_MINUS_MIN : ((c == CH_EQUAL) ? K_MINUS_EQ : 5'd0);
            M_STAR:  k = (c == CH_EQUAL) ? K_STAR_EQ : 5'd0;
            M_SLASH: k = (c == CH_EQUAL) ? K_SLASH_EQ : 5'd0;
            M_EQUAL: k = (c == CH_EQUAL) ? K_EQ_EQ : 5'd0;
            M_BANG:  k = (c == CH_EQUAL) ? K_NOT_EQ : 5'd0;
            M_AMP:   k = (c == CH_AMP) ? K_AND_AND : 5'd0;
            M_PIPE:  k = (c == CH_PIPE) ? K_OR_OR : 5'd0;
            default: k = 5'd0;
        endcase
        return k;
    endfunction

    // Input register.
    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    logic                in_end_reg;

    // Scanner state.
    mode_t               mode_reg, mode_next;
    logic [POS_BITS-1:0] pst_reg, pst_next;
    logic [LEN_W-1:0]    plen_reg, plen_next;
    logic [WBUF_W-1:0]   wbuf_reg, wbuf_next;
    logic                wovf_reg, wovf_next;
    logic [POS_BITS-1:0] bpos_reg, bpos_next;

    logic                advance;
    logic                at_end;
    logic [7:0]          b;
    logic [LEN_W-1:0]    plen_grown;

    logic                fl_emit;
    result_t             fl_res;
    logic                tk_emit;
    result_t             tk_res;
    mode_t               tk_mode;
    logic [POS_BITS-1:0] tk_pst;
    logic [LEN_W-1:0]    tk_plen;
    logic [WBUF_W-1:0]   tk_wbuf;

    logic                a_v, b_v;
    result_t             a_r, b_r;
    logic [4:0]          pk;
    logic [1:0]          nres;

    assign b = in_byte_reg;
    assign at_end = in_end_reg || (in_byte_reg == CH_NUL);
    assign plen_grown = (plen_reg != {LEN_W{1'b1}}) ? plen_reg + 1'b1 : plen_reg;
    assign pk = pair_kind(mode_reg, b);

    // The held byte moves on once its tokens fit in the output buffer.
    assign nres = {1'b0, a_v} + {1'b0, b_v};
    assign advance = in_valid_reg && (nres <= space);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
    end

    // Token that the pending mode leaves behind when it is closed.
    always_comb begin
        fl_emit = 1'b1;
        fl_res  = '{kind: K_BAD, start: 16'(pst_reg), length: '0, last: 1'b0};
        case (mode_reg)
            M_NUMBER: begin
                fl_res.kind   = K_NUMBER;
                fl_res.length = plen_reg;
            end
            M_WORD: begin
                fl_res.length = plen_reg;
                fl_res.kind   = K_IDENT;
                if (!wovf_reg) begin
                    if (64'(wbuf_reg) == words[REG_PRINT]) begin
                        fl_res.kind = K_PRINT;
                    end else if (64'(wbuf_reg) == words[REG_FALSE]) begin
                        fl_res.kind = K_FALSE;
                    end else if (64'(wbuf_reg) == words[REG_TRUE]) begin
                        fl_res.kind = K_TRUE;
                    end else if (64'(wbuf_reg) == words[REG_INT]) begin
                        fl_res.kind = K_INT;
                    end
                end
            end
            M_PLUS: begin
                fl_res.kind   = K_PLUS;
                fl_res.length = LEN_W'(1);
            end
            M_MINUS: begin
                fl_res.kind   = K_MINUS;
                fl_res.length = LEN_W'(1);
            end
            M_STAR: begin
                fl_res.kind   = K_STAR;
                fl_res.length = LEN_W'(1);
            end
            M_SLASH: begin
                fl_res.kind   = K_SLASH;
                fl_res.length = LEN_W'(1);
            end
            M_EQUAL: begin
                fl_res.kind   = K_ASSIGN;
                fl_res.length = LEN_W'(1);
            end
            M_BANG, M_AMP, M_PIPE, M_QUOTE: begin
                fl_res.kind = K_BAD;
            end
            M_STRING: begin
                fl_res.kind   = K_STRING;
                fl_res.length = plen_reg;
            end
            default: begin
                fl_emit = 1'b0;
            end
        endcase
    end

    // How a byte is taken when no token is pending.
    always_comb begin
        tk_emit = 1'b0;
        tk_res  = '{kind: K_BAD, start: 16'(bpos_reg), length: '0, last: 1'b0};
        tk_mode = M_IDLE;
        tk_plen = '0;
        tk_wbuf = '0;
        if (is_space(b)) begin
            tk_mode = M_IDLE;
        end else if (is_digit(b)) begin
            tk_mode = M_NUMBER;
            tk_plen = LEN_W'(1);
        end else if (is_alpha(b)) begin
            tk_mode = M_WORD;
            tk_plen = LEN_W'(1);
            tk_wbuf = WBUF_W'(b);
        end else begin
            case (b)
                CH_PLUS: begin
                    tk_mode = M_PLUS;
                    tk_plen = LEN_W'(1);
                end
                CH_MINUS: begin
                    tk_mode = M_MINUS;
                    tk_plen = LEN_W'(1);
                end
                CH_STAR: begin
                    tk_mode = M_STAR;
                    tk_plen = LEN_W'(1);
                end
                CH_SLASH: begin
                    tk_mode = M_SLASH;
                    tk_plen = LEN_W'(1);
                end
                CH_EQUAL: begin
                    tk_mode = M_EQUAL;
                    tk_plen = LEN_W'(1);
                end
                CH_BANG: begin
                    tk_mode = M_BANG;
                    tk_plen = LEN_W'(1);
                end
                CH_AMP: begin
                    tk_mode = M_AMP;
                    tk_plen = LEN_W'(1);
                end
                CH_PIPE: begin
                    tk_mode = M_PIPE;
                    tk_plen = LEN_W'(1);
                end
                CH_QUOTE: begin
                    tk_mode = M_QUOTE;
                end
                CH_SEMI: begin
                    tk_emit       = 1'b1;
                    tk_res.kind   = K_SEMI;
                    tk_res.length = LEN_W'(1);
                end
                default: begin
                    tk_emit     = 1'b1;
                    tk_res.kind = K_BAD;
                end
            endcase
        end
        tk_pst = (tk_mode == M_IDLE) ? '0 : bpos_reg;
    end

    // Per-byte step: next state and up to two tokens, flushed one first.
    always_comb begin
        logic use_take;
        use_take  = 1'b0;
        mode_next = mode_reg;
        pst_next  = pst_reg;
        plen_next = plen_reg;
        wbuf_next = wbuf_reg;
        wovf_next = wovf_reg;
        bpos_next = bpos_reg + 1'b1;
        a_v = 1'b0;
        a_r = fl_res;
        b_v = 1'b0;
        b_r = tk_res;
        if (at_end) begin
            a_v       = fl_emit;
            b_v       = 1'b1;
            b_r       = '{kind: K_EOF, start: 16'(bpos_reg), length: '0, last: 1'b0};
            mode_next = M_IDLE;
            pst_next  = '0;
            plen_next = '0;
            wbuf_next = '0;
            wovf_next = 1'b0;
            bpos_next = '0;
        end else begin
            case (mode_reg)
                M_IDLE: begin
                    use_take = 1'b1;
                end
                M_NUMBER: begin
                    if (is_digit(b)) begin
                        plen_next = plen_grown;
                    end else begin
                        use_take = 1'b1;
                    end
                end
                M_WORD: begin
                    if (is_alpha(b)) begin
                        plen_next = plen_grown;
                        if (plen_reg < LEN_W'(KW_LETTERS)) begin
                            for (int i = 0; i < KW_LETTERS; i++) begin
                                if (plen_reg == LEN_W'(i)) begin
                                    wbuf_next[i*8 +: 8] = b;
                                end
                            end
                        end else begin
                            wovf_next = 1'b1;
                        end
                    end else begin
                        use_take = 1'b1;
                    end
                end
                M_QUOTE: begin
                    if (is_alpha(b)) begin
                        mode_next = M_STRING;
                        pst_next  = bpos_reg;
                        plen_next = LEN_W'(1);
                        wbuf_next = '0;
                        wovf_next = 1'b0;
                    end else if (b == CH_QUOTE) begin
                        // Empty literal starting at the second quote.
                        b_v       = 1'b1;
                        b_r       = '{kind: K_STRING, start: 16'(bpos_reg), length: '0,
                                      last: 1'b0};
                        mode_next = M_IDLE;
                        pst_next  = '0;
                        plen_next = '0;
                        wbuf_next = '0;
                        wovf_next = 1'b0;
                    end else begin
                        use_take = 1'b1;
                    end
                end
                M_STRING: begin
                    if (is_alpha(b) || is_space(b)) begin
                        plen_next = plen_grown;
                    end else begin
                        // The closing byte is swallowed.
                        a_v       = 1'b1;
                        mode_next = M_IDLE;
                        pst_next  = '0;
                        plen_next = '0;
                        wbuf_next = '0;
                        wovf_next = 1'b0;
                    end
                end
                default: begin
                    if (pk != 5'd0) begin
                        b_v       = 1'b1;
                        b_r       = '{kind: pk, start: 16'(pst_reg), length: LEN_W'(2),
                                      last: 1'b0};
                        mode_next = M_IDLE;
                        pst_next  = '0;
                        plen_next = '0;
                        wbuf_next = '0;
                        wovf_next = 1'b0;
                    end else begin
                        use_take = 1'b1;
                    end
                end
            endcase
            if (use_take) begin
                a_v       = fl_emit;
                a_r       = fl_res;
                b_v       = tk_emit;
                b_r       = tk_res;
                mode_next = tk_mode;
                pst_next  = tk_pst;
                plen_next = tk_plen;
                wbuf_next = tk_wbuf;
                wovf_next = 1'b0;
            end
        end
    end

    // Pack the tokens in order; the final one carries the last flag.
    always_comb begin
        push.cnt     = advance ? nres : 2'd0;
        push.r0      = a_v ? a_r : b_r;
        push.r0.last = !(a_v && b_v);
        push.r1      = b_r;
        push.r1.last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            pst_reg  <= '0;
            plen_reg <= '0;
            wbuf_reg <= '0;
            wovf_reg <= 1'b0;
            bpos_reg <= '0;
        end else if (advance) begin
            mode_reg <= mode_next;
            pst_reg  <= pst_next;
            plen_reg <= plen_next;
            wbuf_reg <= wbuf_next;
            wovf_reg <= wovf_next;
            bpos_reg <= bpos_next;
        end
    end

endmodule

// ===== rtl/stt_obuf.sv =====
`include "source_text_tokenizer_top_macros.svh"

module stt_obuf (
    input  logic            aclk,
    input  logic            aresetn,
    input  stt_pkg::push_t  push,
    output logic [1:0]      space,
    output logic            m_tvalid,
    input  logic            m_tready,
    output stt_pkg::result_t m_res
);
    import stt_pkg::*;

    // Two result slots; slot 0 drives the output channel.
    logic [1:0] cnt_reg, cnt_next;
    result_t    e0_reg, e0_next;
    result_t    e1_reg, e1_next;
    logic       pop;
    logic [1:0] cnt_mid;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_res    = e0_reg;
    assign pop      = m_tvalid && m_tready;
    assign cnt_mid  = cnt_reg - {1'b0, pop};
    assign space    = 2'd2 - cnt_mid;

    // Shift out the taken request, then append the new tokens behind what remains.
    always_comb begin
        e0_next  = pop ? e1_reg : e0_reg;
        e1_next  = e1_reg;
        cnt_next = cnt_mid + push.cnt;
        if (cnt_mid == 2'd0) begin
            if (push.cnt != 2'd0) begin
                e0_next = push.r0;
            end
            e1_next = push.r1;
        end else if (cnt_mid == 2'd1) begin
            if (push.cnt != 2'd0) begin
                e1_next = push.r0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

    `STT_NEVER(a_cnt_max, aclk, aresetn, cnt_reg == 2'd3)
    `STT_NEVER(a_push_fits, aclk, aresetn, push.cnt > space)
    `STT_ASSERT(a_push_shows, aclk, aresetn, (push.cnt != 2'd0) |=> m_tvalid)

endmodule

// ===== rtl/source_text_tokenizer_top.sv =====
// Streaming source text tokenizer.
// Input channel s_*: one source byte per request in s_tdata, s_tlast set marks
// end of text (a zero byte does the same). Output channel m_*: one token per
// request with kind, start position and length in m_tdata; m_tlast marks the
// final token caused by an input byte. Keyword registers are written through
// the cfg_* channel (index 0 print, 1 false, 2 true, 3 int), always ready.
// A byte accepted from s_* is held in the input register, and its tokens
// move into the output buffer once they fit there, from which the first
// one is then offered on m_*. Throughput is one byte per cycle while the
// output buffer has room; a byte that closes a token and yields another
// (or end of text after a pending token) produces two tokens, which leave
// the output one at a time, so a later byte that needs both slots waits in
// the input register. The two-slot output buffer sets this.
// Reset (aresetn low, synchronous) returns the scanner to idle at position
// zero, empties the output buffer and reloads the default keywords.
// When the receiver stalls, tokens wait in the output buffer, the held byte
// waits in the input register, and s_tready drops until space frees up.
module source_text_tokenizer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [4:0] token_kind, [20:5] token_start,
                                   // [36:21] token_length, [39:37] zero
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import stt_pkg::*;

    kw_words_t  words_reg;
    push_t      push;
    logic [1:0] space;
    result_t    m_res;

    // Keyword registers; writes are taken at any time.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            words_reg[REG_PRINT] <= PRINT_RESET;
            words_reg[REG_FALSE] <= FALSE_RESET;
            words_reg[REG_TRUE]  <= TRUE_RESET;
            words_reg[REG_INT]   <= INT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (reg_index_t'(cfg_index))
                REG_PRINT: words_reg[REG_PRINT] <= cfg_data;
                REG_FALSE: words_reg[REG_FALSE] <= cfg_data;
                REG_TRUE:  words_reg[REG_TRUE]  <= cfg_data;
                REG_INT:   words_reg[REG_INT]   <= cfg_data;
                default: ;
            endcase
        end
    end

    stt_scan u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .words    (words_reg),
        .space    (space),
        .push     (push)
    );

    stt_obuf u_obuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res)
    );

    // Output packing.
    assign m_tdata = {3'b000, m_res.length, m_res.start, m_res.kind};
    assign m_tlast = m_res.last;

endmodule

// ===== sim/source_text_tokenizer_top_test.sv =====
module source_text_tokenizer_top_test;
    import stt_pkg::*;

    // Cycles allowed with no request moving on any channel.
    localparam int STALL_LIMIT = 4000;
    // Quiet cycles after the last token, covering the input register and output buffer.
    localparam int TAIL_CYCLES = 8;

    // One source byte with an optional hand-written expectation.
    typedef struct packed {
        logic [7:0] text;
        logic       eot;
        logic       typed;
        result_t    tok;
    } item_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    source_text_tokenizer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Scanner state mirrored by the token predictor.
    logic [63:0] kw [NUM_WORDS];
    mode_t       mode;
    logic [15:0] pend_start;
    logic [15:0] pend_len;
    logic [63:0] word_buf;
    logic [15:0] byte_pos;
    logic        word_ovf;

    result_t     fresh [$];
    result_t     tokens_due [$];
    bit          no_idle = 1'b0;
    int          mismatches = 0;
    int          bytes_sent = 0;
    int          tokens_seen = 0;
    int          texts_ended = 0;
    int          idle_cycles = 0;
    logic [24:0] kinds_seen = '0;

    string op_spellings [19] = '{"+", "++", "+=", "-", "--", "-=", "*", "*=", "/", "/=",
                                 "=", "==", "!=", "&&", "||", ";", "!", "&", "|"};

    // Directed text: tokens with fixed expectations are typed in, the rest are predicted.
    item_t script [27] = '{
        '{8'h3B, 1'b0, 1'b1, '{K_SEMI, 16'd0, 16'd1, 1'b1}}, // semicolon at the first byte
        '{8'hFF, 1'b0, 1'b1, '{K_BAD, 16'd1, 16'd0, 1'b1}},  // top byte value is bad
        '{"p", 1'b0, 1'b0, '0},
        '{"r", 1'b0, 1'b0, '0},
        '{"i", 1'b0, 1'b0, '0},
        '{"n", 1'b0, 1'b0, '0},
        '{"t", 1'b0, 1'b0, '0},
        '{" ", 1'b0, 1'b0, '0},                              // closes the print keyword
        '{"!", 1'b0, 1'b0, '0},
        '{"x", 1'b0, 1'b0, '0},                              // lone bang, then a word
        '{8'h22, 1'b0, 1'b0, '0},
        '{8'h22, 1'b0, 1'b0, '0},                            // two quotes: empty string
        '{8'h22, 1'b0, 1'b0, '0},
        '{"7", 1'b0, 1'b0, '0},                              // quote before a digit is bad
        '{"&", 1'b0, 1'b0, '0},
        '{"&", 1'b0, 1'b0, '0},
        '{"|", 1'b0, 1'b0, '0},
        '{" ", 1'b0, 1'b0, '0},                              // lone pipe is bad
        '{8'h22, 1'b0, 1'b0, '0},
        '{"a", 1'b0, 1'b0, '0},
        '{" ", 1'b0, 1'b0, '0},
        '{".", 1'b0, 1'b0, '0},                              // period closes the literal
        '{"-", 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},                            // zero byte flushes the minus
        '{" ", 1'b0, 1'b0, '0},
        '{8'hA5, 1'b1, 1'b1, '{K_EOF, 16'd1, 16'd0, 1'b1}},  // trailing blank gives eof only
        '{8'h00, 1'b1, 1'b1, '{K_EOF, 16'd0, 16'd0, 1'b1}}   // empty text
    };

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic bit is_blank(logic [7:0] b);
        return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic bit is_numeral(logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic bit is_letter(logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    endfunction

    function automatic void post(logic [4:0] kind, logic [15:0] start, logic [15:0] len);
        result_t r;
        r.kind = kind;
        r.start = start;
        r.length = len;
        r.last = 1'b0;
        fresh.push_back(r);
    endfunction

    function automatic void open_token(mode_t m, logic [15:0] start, logic [15:0] len);
        mode = m;
        pend_start = start;
        pend_len = len;
        word_buf = '0;
        word_ovf = 1'b0;
    endfunction

    function automatic void lengthen();
        if (pend_len != 16'hFFFF) begin
            pend_len = pend_len + 16'd1;
        end
    endfunction

    // Only the first keyword-sized part of a word is kept for matching.
    function automatic void take_letter(logic [7:0] b);
        if (pend_len < KW_LETTERS) begin
            word_buf[8*pend_len +: 8] = b;
        end else begin
            word_ovf = 1'b1;
        end
        lengthen();
    endfunction

    function automatic logic [4:0] word_token();
        if (!word_ovf) begin
            if (word_buf == kw[REG_PRINT]) return K_PRINT;
            if (word_buf == kw[REG_FALSE]) return K_FALSE;
            if (word_buf == kw[REG_TRUE]) return K_TRUE;
            if (word_buf == kw[REG_INT]) return K_INT;
        end
        return K_IDENT;
    endfunction

    // Two-byte operator formed by the held operator and b; K_EOF means none.
    function automatic logic [4:0] pair_token(mode_t m, logic [7:0] b);
        case (m)
            M_PLUS: begin
                if (b == CH_PLUS) return K_PLUS_PLUS;
                if (b == CH_EQUAL) return K_PLUS_EQ;
            end
            M_MINUS: begin
                if (b == CH_MINUS) return K_MINUS_MIN;
                if (b == CH_EQUAL) return K_MINUS_EQ;
            end
            M_STAR:  if (b == CH_EQUAL) return K_STAR_EQ;
            M_SLASH: if (b == CH_EQUAL) return K_SLASH_EQ;
            M_EQUAL: if (b == CH_EQUAL) return K_EQ_EQ;
            M_BANG:  if (b == CH_EQUAL) return K_NOT_EQ;
            M_AMP:   if (b == CH_AMP) return K_AND_AND;
            M_PIPE:  if (b == CH_PIPE) return K_OR_OR;
            default: ;
        endcase
        return K_EOF;
    endfunction

    // Emit whatever token is held and go back to idle.
    function automatic void flush_pending();
        case (mode)
            M_NUMBER: post(K_NUMBER, pend_start, pend_len);
            M_WORD:   post(word_token(), pend_start, pend_len);
            M_PLUS:   post(K_PLUS, pend_start, 16'd1);
            M_MINUS:  post(K_MINUS, pend_start, 16'd1);
            M_STAR:   post(K_STAR, pend_start, 16'd1);
            M_SLASH:  post(K_SLASH, pend_start, 16'd1);
            M_EQUAL:  post(K_ASSIGN, pend_start, 16'd1);
            M_BANG, M_AMP, M_PIPE, M_QUOTE: post(K_BAD, pend_start, 16'd0);
            M_STRING: post(K_STRING, pend_start, pend_len);
            default: ;
        endcase
        open_token(M_IDLE, 16'd0, 16'd0);
    endfunction

    // A byte seen with nothing held.
    function automatic void start_token(logic [7:0] b, logic [15:0] pos);
        if (is_blank(b)) begin
            return;
        end else if (is_numeral(b)) begin
            open_token(M_NUMBER, pos, 16'd1);
        end else if (is_letter(b)) begin
            open_token(M_WORD, pos, 16'd0);
            take_letter(b);
        end else begin
            case (b)
                CH_PLUS:  open_token(M_PLUS, pos, 16'd1);
                CH_MINUS: open_token(M_MINUS, pos, 16'd1);
                CH_STAR:  open_token(M_STAR, pos, 16'd1);
                CH_SLASH: open_token(M_SLASH, pos, 16'd1);
                CH_EQUAL: open_token(M_EQUAL, pos, 16'd1);
                CH_BANG:  open_token(M_BANG, pos, 16'd1);
                CH_AMP:   open_token(M_AMP, pos, 16'd1);
                CH_PIPE:  open_token(M_PIPE, pos, 16'd1);
                CH_QUOTE: open_token(M_QUOTE, pos, 16'd0);
                CH_SEMI:  post(K_SEMI, pos, 16'd1);
                default:  post(K_BAD, pos, 16'd0);
            endcase
        end
    endfunction

    // Tokens caused by one accepted byte, left in fresh with the last one marked.
    function automatic void tokenize_byte(logic [7:0] b, logic eot);
        logic [15:0] pos;
        logic [4:0]  pk;
        pos = byte_pos;
        fresh.delete();
        if (eot || b == CH_NUL) begin
            flush_pending();
            post(K_EOF, pos, 16'd0);
            byte_pos = 16'd0;
        end else begin
            case (mode)
                M_IDLE: start_token(b, pos);
                M_NUMBER: begin
                    if (is_numeral(b)) begin
                        lengthen();
                    end else begin
                        flush_pending();
                        start_token(b, pos);
                    end
                end
                M_WORD: begin
                    if (is_letter(b)) begin
                        take_letter(b);
                    end else begin
                        flush_pending();
                        start_token(b, pos);
                    end
                end
                M_QUOTE: begin
                    if (is_letter(b)) begin
                        open_token(M_STRING, pos, 16'd1);
                    end else if (b == CH_QUOTE) begin
                        post(K_STRING, pos, 16'd0);
                        open_token(M_IDLE, 16'd0, 16'd0);
                    end else begin
                        flush_pending();
                        start_token(b, pos);
                    end
                end
                M_STRING: begin
                    if (is_letter(b) || is_blank(b)) begin
                        lengthen();
                    end else begin
                        flush_pending();
                    end
                end
                default: begin
                    pk = pair_token(mode, b);
                    if (pk != K_EOF) begin
                        post(pk, pend_start, 16'd2);
                        open_token(M_IDLE, 16'd0, 16'd0);
                    end else begin
                        flush_pending();
                        start_token(b, pos);
                    end
                end
            endcase
            byte_pos = pos + 16'd1;
        end
        if (fresh.size() > 0) begin
            fresh[fresh.size()-1].last = 1'b1;
        end
    endfunction

    function automatic item_t plain(logic [7:0] b, logic e);
        item_t it;
        it = '0;
        it.text = b;
        it.eot = e;
        return it;
    endfunction

    function automatic logic [7:0] any_letter();
        if ($urandom_range(1) == 0) return 8'h41 + 8'($urandom_range(25));
        return 8'h61 + 8'($urandom_range(25));
    endfunction

    function automatic logic [7:0] any_blank();
        if ($urandom_range(5) == 0) return 8'h20;
        return 8'h09 + 8'($urandom_range(4));
    endfunction

    // Offer one byte, wait for its request to be taken, then predict its tokens.
    task automatic send_item(input item_t it);
        while (!no_idle && $urandom_range(99) < 38) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= it.text;
        s_tlast <= it.eot;
        do @(posedge aclk); while (!s_tready);
        tokenize_byte(it.text, it.eot);
        if (it.typed) begin
            tokens_due.push_back(it.tok);
        end else begin
            foreach (fresh[i]) tokens_due.push_back(fresh[i]);
        end
        bytes_sent++;
        @(negedge aclk);
    endtask

    // Let every predicted token come out and the pipeline empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (tokens_due.size() != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
    endtask

    task automatic write_keyword(reg_index_t idx, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        kw[idx] = value;
        @(negedge aclk);
    endtask

    task automatic load_keywords(logic [63:0] p, logic [63:0] f, logic [63:0] t,
                                 logic [63:0] i);
        write_keyword(REG_PRINT, p);
        write_keyword(REG_FALSE, f);
        write_keyword(REG_TRUE, t);
        write_keyword(REG_INT, i);
        cfg_valid <= 1'b0;
    endtask

    // Random source text built from plausible tokens, with noise and early ends mixed in.
    task automatic run_random(int count, int calm_from, int calm_to);
        item_t       chunk [$];
        int          sent;
        int          pick;
        int          n;
        logic [63:0] w;
        logic [7:0]  c;
        bit          usable;
        string       op;
        sent = 0;
        while (sent < count) begin
            chunk.delete();
            pick = $urandom_range(99);
            if (pick < 15) begin
                n = $urandom_range(1, 12);
                repeat (n) chunk.push_back(plain(any_letter(), 1'b0));
            end else if (pick < 25) begin
                // Spell a keyword register when it holds letters, sometimes one too long.
                w = kw[$urandom_range(NUM_WORDS - 1)];
                usable = 1'b1;
                for (int i = 0; i < KW_LETTERS; i++) begin
                    c = w[8*i +: 8];
                    if (c == CH_NUL) break;
                    if (!is_letter(c)) usable = 1'b0;
                    chunk.push_back(plain(c, 1'b0));
                end
                if (!usable || chunk.size() == 0) begin
                    chunk.delete();
                    chunk.push_back(plain(any_letter(), 1'b0));
                end else if ($urandom_range(9) == 0) begin
                    chunk.push_back(plain(any_letter(), 1'b0));
                end
            end else if (pick < 37) begin
                n = $urandom_range(1, 6);
                repeat (n) chunk.push_back(plain(8'h30 + 8'($urandom_range(9)), 1'b0));
            end else if (pick < 57) begin
                op = op_spellings[$urandom_range(18)];
                for (int i = 0; i < op.len(); i++) chunk.push_back(plain(op[i], 1'b0));
            end else if (pick < 67) begin
                // Literal of letters and blanks; usually closed by punctuation or a digit.
                chunk.push_back(plain(CH_QUOTE, 1'b0));
                n = $urandom_range(8);
                repeat (n) begin
                    c = ($urandom_range(3) == 0) ? any_blank() : any_letter();
                    chunk.push_back(plain(c, 1'b0));
                end
                if ($urandom_range(4) != 0) begin
                    chunk.push_back(plain(8'($urandom_range(33, 64)), 1'b0));
                end
            end else if (pick < 85) begin
                n = $urandom_range(1, 3);
                repeat (n) chunk.push_back(plain(any_blank(), 1'b0));
            end else if (pick < 95) begin
                chunk.push_back(plain(8'($urandom_range(1, 255)), 1'b0));
            end else if ($urandom_range(1) == 0) begin
                chunk.push_back(plain(8'($urandom_range(255)), 1'b1));
            end else begin
                chunk.push_back(plain(CH_NUL, 1'b0));
            end
            foreach (chunk[i]) begin
                no_idle = (sent >= calm_from && sent < calm_to);
                send_item(chunk[i]);
                sent++;
            end
        end
        no_idle = 1'b0;
        send_item(plain(CH_NUL, 1'b1));
    endtask

    // Receiver side: random back-pressure unless a calm stretch is running.
    always @(negedge aclk) begin
        m_tready <= no_idle || ($urandom_range(99) >= 38);
    end

    // Compare each token taken with the oldest prediction.
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = m_tdata[4:0];
            got.start = m_tdata[20:5];
            got.length = m_tdata[36:21];
            got.last = m_tlast;
            tokens_seen++;
            if (tokens_due.size() == 0) begin
                $error("unexpected token: kind %0d, start %0d, length %0d",
                       got.kind, got.start, got.length);
                mismatches++;
            end else begin
                want = tokens_due.pop_front();
                kinds_seen[want.kind] = 1'b1;
                if (want.kind == K_EOF) texts_ended++;
                if (got.kind !== want.kind) begin
                    $error("token_kind: expected %0d, got %0d", want.kind, got.kind);
                    mismatches++;
                end
                if (got.start !== want.start) begin
                    $error("token_start: expected %0d, got %0d", want.start, got.start);
                    mismatches++;
                end
                if (got.length !== want.length) begin
                    $error("token_length: expected %0d, got %0d", want.length, got.length);
                    mismatches++;
                end
                if (got.last !== want.last) begin
                    $error("last_result: expected %0d, got %0d", want.last, got.last);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles where no request moves on any channel.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("stalled: %0d tokens still expected", tokens_due.size());
                $display("** source_text_tokenizer_top: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_PRINT;
        cfg_data = '0;
        kw[REG_PRINT] = PRINT_RESET;
        kw[REG_FALSE] = FALSE_RESET;
        kw[REG_TRUE] = TRUE_RESET;
        kw[REG_INT] = INT_RESET;
        open_token(M_IDLE, 16'd0, 16'd0);
        byte_pos = 16'd0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Default keywords: directed text, then random text.
        foreach (script[i]) send_item(script[i]);
        run_random(225, -1, -1);
        settle();

        // Eight-letter keyword, one-letter keyword, all-zero and all-one registers.
        load_keywords(64'h6867_6665_6463_6261, 64'h78, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        run_random(225, 60, 180);
        settle();

        // Mixed-case and full-width keywords.
        load_keywords(64'h74_6E69_7250, 64'h6F6E, 64'h73_6579, 64'h7372_6567_6574_6E69);
        run_random(225, -1, -1);
        settle();

        $display("Covered %0d source bytes over %0d texts; %0d tokens checked, %0d of 25 kinds.",
                 bytes_sent, texts_ended, tokens_seen, $countones(kinds_seen));
        $display("Keywords ran at reset, edge and mixed-case values, with and without stalls.");
        if (mismatches == 0) begin
            $display("** source_text_tokenizer_top: PASSED **");
        end else begin
            $display("** source_text_tokenizer_top: FAILED **");
        end
        $finish;
    end

endmodule
